[rtl/core/rpf_pkg.sv]
// shared constants, result codes, job descriptor and crc-16 step for the packet framer
// no dependencies
`timescale 1ns / 1ps

package rpf_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int CRC_W       = 16;

    localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_MSB  = 16'h8000;
    localparam logic [BYTE_W-1:0] PREAMBLE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_HI  = 8'h2D;
    localparam logic [BYTE_W-1:0] SYNC_LO  = 8'hD4;

    localparam logic OP_TX = 1'b0;
    localparam logic OP_RX = 1'b1;

    localparam logic [1:0] KIND_TX_LINE = 2'd0;
    localparam logic [1:0] KIND_RX_BYTE = 2'd1;
    localparam logic [1:0] KIND_RX_DONE = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_BUSY   = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;

    // line byte positions of a transmit frame
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_PRE0    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_PRE1    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PRE2    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SYNC0   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SYNC1   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_LEN     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PAYLOAD = 4'd6;
    localparam logic [STEP_W-1:0] STEP_CRC_LO  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CRC_HI  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_TRAIL0  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_TRAIL1  = 4'd10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        logic              crc_ok;
        logic [1:0]        err;
        logic              hdr;
        logic              pay;
        logic              tail;
        logic [CRC_W-1:0]  crc;
    } job_t;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic [CRC_W-1:0] feed;
        c    = crc_in;
        feed = {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (((c ^ feed) & CRC_MSB) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
            feed = {feed[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/core/rpf_front.sv]
// front end: accepts words, tracks tx/rx mode, counters and crc, issues jobs
// depends on rpf_pkg
`timescale 1ns / 1ps

module rpf_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_op,
    input  logic [rpf_pkg::BYTE_W-1:0]  s_data_byte,
    input  logic [rpf_pkg::LEN_W-1:0]   s_tx_length,
    output logic                        q_wr,
    output rpf_pkg::job_t               q_job,
    input  logic                        q_full
);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_TX   = 2'd1;
    localparam logic [1:0] MODE_RX   = 2'd2;

    logic [1:0]                       mode_reg, mode_next;
    logic [rpf_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic [rpf_pkg::LEN_W-1:0]        plen_reg, plen_next;
    logic [rpf_pkg::CRC_W-1:0]        crc_reg, crc_next;
    logic [rpf_pkg::BYTE_W-1:0]       crc_low_reg, crc_low_next;
    logic                             pend_reg, pend_next;
    logic [rpf_pkg::BYTE_W-1:0]       pend_byte_reg, pend_byte_next;

    logic                             accept;
    logic [rpf_pkg::BYTE_W-1:0]       run_byte;
    logic [rpf_pkg::BYTE_W-1:0]       start_len;
    logic [rpf_pkg::CRC_W-1:0]        crc_run;
    logic [rpf_pkg::CRC_W-1:0]        crc_start;
    logic [rpf_pkg::LEN_W-1:0]        cnt_inc;
    logic                             tx_tail;
    logic                             tx_run;

    assign s_tready  = !pend_reg && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign run_byte  = pend_reg ? pend_byte_reg : s_data_byte;
    assign start_len = (s_op == rpf_pkg::OP_TX) ? {1'b0, s_tx_length} : s_data_byte;
    assign crc_run   = rpf_pkg::crc_step(crc_reg, run_byte);
    assign crc_start = rpf_pkg::crc_step('0, start_len);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign tx_tail   = cnt_inc >= plen_reg;
    assign tx_run    = (pend_reg && !q_full)
                    || (accept && s_op == rpf_pkg::OP_TX && mode_reg == MODE_TX);

    always_comb begin
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        plen_next      = plen_reg;
        crc_next       = crc_reg;
        crc_low_next   = crc_low_reg;
        pend_next      = pend_reg;
        pend_byte_next = pend_byte_reg;
        q_wr           = 1'b0;
        q_job          = '0;

        if (tx_run) begin
            // payload byte of a transmit packet, header too when it opens the packet
            q_wr       = 1'b1;
            q_job.kind = rpf_pkg::KIND_TX_LINE;
            q_job.data = run_byte;
            q_job.len  = plen_reg;
            q_job.hdr  = pend_reg;
            q_job.pay  = 1'b1;
            q_job.tail = tx_tail;
            q_job.crc  = crc_run;
            crc_next   = crc_run;
            pend_next  = 1'b0;
            if (tx_tail) begin
                mode_next = MODE_IDLE;
                cnt_next  = '0;
            end else begin
                cnt_next  = cnt_inc;
            end
        end else if (accept && s_op == rpf_pkg::OP_TX) begin
            if (mode_reg == MODE_RX) begin
                q_wr       = 1'b1;
                q_job.kind = rpf_pkg::KIND_ERROR;
                q_job.err  = rpf_pkg::ERR_BUSY;
            end else if (s_tx_length > rpf_pkg::LEN_W'(rpf_pkg::MAX_PAYLOAD)) begin
                q_wr       = 1'b1;
                q_job.kind = rpf_pkg::KIND_ERROR;
                q_job.err  = rpf_pkg::ERR_LENGTH;
            end else begin
                plen_next = s_tx_length;
                crc_next  = crc_start;
                cnt_next  = '0;
                if (s_tx_length == '0) begin
                    // empty frame: header, crc and trailer at once
                    q_wr       = 1'b1;
                    q_job.kind = rpf_pkg::KIND_TX_LINE;
                    q_job.len  = s_tx_length;
                    q_job.hdr  = 1'b1;
                    q_job.tail = 1'b1;
                    q_job.crc  = crc_start;
                    mode_next  = MODE_IDLE;
                end else begin
                    // length crc now, payload byte crc once the pending byte is queued
                    mode_next      = MODE_TX;
                    pend_next      = 1'b1;
                    pend_byte_next = s_data_byte;
                end
            end
        end else if (accept) begin
            if (mode_reg == MODE_TX) begin
                q_wr       = 1'b1;
                q_job.kind = rpf_pkg::KIND_ERROR;
                q_job.err  = rpf_pkg::ERR_BUSY;
            end else if (mode_reg != MODE_RX) begin
                if (s_data_byte > rpf_pkg::BYTE_W'(rpf_pkg::MAX_PAYLOAD)) begin
                    q_wr       = 1'b1;
                    q_job.kind = rpf_pkg::KIND_ERROR;
                    q_job.err  = rpf_pkg::ERR_LENGTH;
                end else begin
                    plen_next = s_data_byte[rpf_pkg::LEN_W-1:0];
                    crc_next  = crc_start;
                    cnt_next  = '0;
                    mode_next = MODE_RX;
                end
            end else if (cnt_reg < plen_reg) begin
                q_wr       = 1'b1;
                q_job.kind = rpf_pkg::KIND_RX_BYTE;
                q_job.data = s_data_byte;
                crc_next   = crc_run;
                cnt_next   = cnt_inc;
            end else if (cnt_reg == plen_reg) begin
                crc_low_next = s_data_byte;
                cnt_next     = cnt_inc;
            end else begin
                q_wr         = 1'b1;
                q_job.kind   = rpf_pkg::KIND_RX_DONE;
                q_job.len    = plen_reg;
                q_job.crc_ok = ({s_data_byte, crc_low_reg} == crc_reg);
                mode_next    = MODE_IDLE;
                cnt_next     = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            cnt_reg     <= '0;
            plen_reg    <= '0;
            crc_reg     <= '0;
            crc_low_reg <= '0;
            pend_reg    <= 1'b0;
        end else begin
            mode_reg    <= mode_next;
            cnt_reg     <= cnt_next;
            plen_reg    <= plen_next;
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
            pend_reg    <= pend_next;
        end
        pend_byte_reg <= pend_byte_next;
    end

endmodule

[rtl/core/rpf_queue.sv]
// small job queue between front end and back end
// depends on rpf_pkg
`timescale 1ns / 1ps

module rpf_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr,
    input  rpf_pkg::job_t wr_job,
    output logic          full,
    input  logic          rd,
    output rpf_pkg::job_t rd_job,
    output logic          empty
);

    rpf_pkg::job_t                    mem_reg [rpf_pkg::QUEUE_DEPTH];
    logic [rpf_pkg::QUEUE_AW-1:0]     wptr_reg, wptr_next;
    logic [rpf_pkg::QUEUE_AW-1:0]     rptr_reg, rptr_next;
    logic [rpf_pkg::QUEUE_CW-1:0]     count_reg, count_next;

    assign full   = count_reg == rpf_pkg::QUEUE_CW'(rpf_pkg::QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign rd_job = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (wr && !rd) begin
            count_next = count_reg + 1'b1;
        end else if (rd && !wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (wr) begin
            mem_reg[wptr_reg] <= wr_job;
        end
    end

endmodule

[rtl/core/rpf_back.sv]
// back end: expands each job into result words, one per cycle while m_tready allows, into the output register
// depends on rpf_pkg
`timescale 1ns / 1ps

module rpf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  rpf_pkg::job_t               q_job,
    output logic                        q_rd,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic [1:0]                  m_tuser,
    output logic                        m_tlast
);

    rpf_pkg::job_t                      cur_reg;
    logic                               cur_valid_reg, cur_valid_next;
    logic [rpf_pkg::STEP_W-1:0]         step_reg, step_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [23:0]                        m_tdata_reg;
    logic [1:0]                         m_tuser_reg;
    logic                               m_tlast_reg;

    logic                               out_free;
    logic                               emit;
    logic                               is_last;
    logic [rpf_pkg::STEP_W-1:0]         first_step;
    logic [rpf_pkg::BYTE_W-1:0]         line_byte;
    logic [rpf_pkg::BYTE_W-1:0]         res_byte;
    logic [rpf_pkg::LEN_W-1:0]          res_len;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = cur_valid_reg && out_free;
    assign is_last  = (cur_reg.kind != rpf_pkg::KIND_TX_LINE)
                   || (step_reg == rpf_pkg::STEP_TRAIL1)
                   || (step_reg == rpf_pkg::STEP_PAYLOAD && !cur_reg.tail);
    assign q_rd     = !q_empty && (!cur_valid_reg || (emit && is_last));

    always_comb begin
        if (q_job.hdr) begin
            first_step = rpf_pkg::STEP_PRE0;
        end else if (q_job.pay) begin
            first_step = rpf_pkg::STEP_PAYLOAD;
        end else begin
            first_step = rpf_pkg::STEP_CRC_LO;
        end
    end

    always_comb begin
        unique case (step_reg) inside
            rpf_pkg::STEP_PRE0, rpf_pkg::STEP_PRE1, rpf_pkg::STEP_PRE2,
            rpf_pkg::STEP_TRAIL0, rpf_pkg::STEP_TRAIL1: line_byte = rpf_pkg::PREAMBLE;
            rpf_pkg::STEP_SYNC0:   line_byte = rpf_pkg::SYNC_HI;
            rpf_pkg::STEP_SYNC1:   line_byte = rpf_pkg::SYNC_LO;
            rpf_pkg::STEP_LEN:     line_byte = {1'b0, cur_reg.len};
            rpf_pkg::STEP_PAYLOAD: line_byte = cur_reg.data;
            rpf_pkg::STEP_CRC_LO:  line_byte = cur_reg.crc[7:0];
            rpf_pkg::STEP_CRC_HI:  line_byte = cur_reg.crc[15:8];
            default:               line_byte = '0;
        endcase
    end

    assign res_byte = (cur_reg.kind == rpf_pkg::KIND_TX_LINE) ? line_byte : cur_reg.data;
    assign res_len  = (cur_reg.kind == rpf_pkg::KIND_RX_DONE) ? cur_reg.len : '0;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (q_rd) begin
            cur_valid_next = 1'b1;
            step_next      = first_step;
        end else if (emit && is_last) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            // empty frame skips from length byte to crc
            if (step_reg == rpf_pkg::STEP_LEN && !cur_reg.pay) begin
                step_next = rpf_pkg::STEP_CRC_LO;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
        m_tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        if (q_rd) begin
            cur_reg <= q_job;
        end
        if (emit) begin
            m_tdata_reg <= {6'b0, cur_reg.err, cur_reg.crc_ok, res_len, res_byte};
            m_tuser_reg <= cur_reg.kind;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/core/radio_packet_framer_crc16.sv]
// top level of the radio packet framer / deframer with crc-16
// depends on rpf_pkg, rpf_front, rpf_queue, rpf_back
//
// channel  dir  tdata (low bit up)                                   tuser  tlast
// s_       in   data_byte[7:0] tx_length[14:8] pad[15]               op     -
// m_       out  out_byte[7:0] rx_length[14:8] crc_ok[15] err[17:16]  kind   last of word
//
// the front end takes one word per cycle while the queue is not full; a transmit word that opens
// a packet with payload holds s_tready low until the second crc byte update has been queued
// the back end sends one result per cycle while m_tready allows, so a word yields 0 to 11 result
// words (11 for a one-byte packet: header, payload, crc and trailer)
// a four-entry job queue lets the front keep accepting while results wait on m_tready
// aresetn (synchronous, active low) returns both directions to idle and empties the queue
`timescale 1ns / 1ps

module radio_packet_framer_crc16 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], tx_length[14:8]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte[7:0], rx_length[14:8], crc_ok[15], error_code[17:16]
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast
);

    rpf_pkg::job_t wr_job;
    rpf_pkg::job_t rd_job;
    logic          q_wr;
    logic          q_full;
    logic          q_rd;
    logic          q_empty;

    rpf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_op        (s_tuser),
        .s_data_byte (s_tdata[7:0]),
        .s_tx_length (s_tdata[14:8]),
        .q_wr        (q_wr),
        .q_job       (wr_job),
        .q_full      (q_full)
    );

    rpf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_job  (wr_job),
        .full    (q_full),
        .rd      (q_rd),
        .rd_job  (rd_job),
        .empty   (q_empty)
    );

    rpf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (rd_job),
        .q_rd     (q_rd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[rtl/core/rpf_checker.sv]
// port-level checks for the radio packet framer, bound to the top level
// depends on rpf_pkg and radio_packet_framer_crc16
`timescale 1ns / 1ps

module rpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result word changed under stall");

    // receive and error results always stand alone
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != rpf_pkg::KIND_TX_LINE |-> m_tlast)
        else $error("non-transmit result not marked last");

    // an error result carries a code, other results none
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == rpf_pkg::KIND_ERROR) == (m_tdata[17:16] != rpf_pkg::ERR_NONE)))
        else $error("error code does not match result kind");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind radio_packet_framer_crc16 rpf_checker u_rpf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[verif/rpf_frame_checker.sv]
// scoreboard for the radio packet framer: watches both stream channels, predicts
// every result word from the accepted input words and compares them in order
// depends on rpf_pkg; also holds rpf_tb_pkg, the crc helper shared with the stimulus
`timescale 1ns / 1ps

package rpf_tb_pkg;

    import rpf_pkg::*;

    // crc-16, poly 0x1021, msb first, byte folded into the high half
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

module rpf_frame_checker
    import rpf_pkg::*, rpf_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], tx_length[14:8]
    input  logic        s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // out_byte[7:0], rx_length[14:8], crc_ok[15], error_code[17:16]
    input  logic [1:0]  m_tuser,   // kind
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    typedef enum logic [1:0] {LINK_IDLE, LINK_TX, LINK_RX} link_mode_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] len;
        logic       ok;
        logic [1:0] err;
        logic       last;
    } frame_word_t;

    frame_word_t expected_words[$];
    frame_word_t step_words[$];

    link_mode_e  link_mode;
    logic [7:0]  byte_cnt;
    logic [7:0]  pkt_len;
    logic [15:0] crc_acc;
    logic [7:0]  crc_low_rx;

    task automatic emit(input logic [1:0] kind, input logic [7:0] data,
                        input logic [6:0] len, input logic ok, input logic [1:0] err);
        frame_word_t w;
        w.kind = kind;
        w.data = data;
        w.len  = len;
        w.ok   = ok;
        w.err  = err;
        w.last = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic emit_tail();
        emit(KIND_TX_LINE, crc_acc[7:0], '0, 1'b0, ERR_NONE);
        emit(KIND_TX_LINE, crc_acc[15:8], '0, 1'b0, ERR_NONE);
        emit(KIND_TX_LINE, PREAMBLE, '0, 1'b0, ERR_NONE);
        emit(KIND_TX_LINE, PREAMBLE, '0, 1'b0, ERR_NONE);
        link_mode = LINK_IDLE;
        byte_cnt  = '0;
    endtask

    task automatic predict_word(input logic op, input logic [7:0] b, input logic [6:0] tl);
        frame_word_t w;
        step_words.delete();
        if (op == OP_TX) begin
            if (link_mode == LINK_RX) begin
                emit(KIND_ERROR, '0, '0, 1'b0, ERR_BUSY);
            end else if (link_mode == LINK_TX) begin
                emit(KIND_TX_LINE, b, '0, 1'b0, ERR_NONE);
                crc_acc  = crc16_update(crc_acc, b);
                byte_cnt = byte_cnt + 8'd1;
                if (byte_cnt >= pkt_len) emit_tail();
            end else if (tl > MAX_PAYLOAD) begin
                emit(KIND_ERROR, '0, '0, 1'b0, ERR_LENGTH);
            end else begin
                pkt_len = {1'b0, tl};
                emit(KIND_TX_LINE, PREAMBLE, '0, 1'b0, ERR_NONE);
                emit(KIND_TX_LINE, PREAMBLE, '0, 1'b0, ERR_NONE);
                emit(KIND_TX_LINE, PREAMBLE, '0, 1'b0, ERR_NONE);
                emit(KIND_TX_LINE, SYNC_HI, '0, 1'b0, ERR_NONE);
                emit(KIND_TX_LINE, SYNC_LO, '0, 1'b0, ERR_NONE);
                emit(KIND_TX_LINE, {1'b0, tl}, '0, 1'b0, ERR_NONE);
                crc_acc   = crc16_update(16'h0000, {1'b0, tl});
                byte_cnt  = '0;
                link_mode = LINK_TX;
                if (tl == '0) begin
                    emit_tail();
                end else begin
                    emit(KIND_TX_LINE, b, '0, 1'b0, ERR_NONE);
                    crc_acc  = crc16_update(crc_acc, b);
                    byte_cnt = 8'd1;
                    if (byte_cnt >= pkt_len) emit_tail();
                end
            end
        end else begin
            if (link_mode == LINK_TX) begin
                emit(KIND_ERROR, '0, '0, 1'b0, ERR_BUSY);
            end else if (link_mode != LINK_RX) begin
                if (b > MAX_PAYLOAD) begin
                    emit(KIND_ERROR, '0, '0, 1'b0, ERR_LENGTH);
                end else begin
                    pkt_len   = b;
                    crc_acc   = crc16_update(16'h0000, b);
                    byte_cnt  = '0;
                    link_mode = LINK_RX;
                end
            end else if (byte_cnt < pkt_len) begin
                emit(KIND_RX_BYTE, b, '0, 1'b0, ERR_NONE);
                crc_acc  = crc16_update(crc_acc, b);
                byte_cnt = byte_cnt + 8'd1;
            end else if (byte_cnt == pkt_len) begin
                crc_low_rx = b;
                byte_cnt   = byte_cnt + 8'd1;
            end else begin
                emit(KIND_RX_DONE, '0, pkt_len[6:0], {b, crc_low_rx} == crc_acc, ERR_NONE);
                link_mode = LINK_IDLE;
                byte_cnt  = '0;
            end
        end
        if (step_words.size() > 0) begin
            w = step_words.pop_back();
            w.last = 1'b1;
            step_words.push_back(w);
        end
        while (step_words.size() > 0) expected_words.push_back(step_words.pop_front());
    endtask

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        frame_word_t want;
        if (!aresetn) begin
            link_mode  = LINK_IDLE;
            byte_cnt   = '0;
            pkt_len    = '0;
            crc_acc    = '0;
            crc_low_rx = '0;
            expected_words.delete();
            errors     = 0;
        end else begin
            if (s_tvalid && s_tready) predict_word(s_tuser, s_tdata[7:0], s_tdata[14:8]);
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected word, expected none, got kind %0d data %0h",
                             $time, m_tuser, m_tdata[17:0]);
                end else begin
                    want = expected_words.pop_front();
                    compare_field("kind", want.kind, m_tuser);
                    compare_field("out_byte", want.data, m_tdata[7:0]);
                    compare_field("rx_length", want.len, m_tdata[14:8]);
                    compare_field("crc_ok", want.ok, m_tdata[15]);
                    compare_field("error_code", want.err, m_tdata[17:16]);
                    compare_field("last", want.last, m_tlast);
                end
            end
        end
        pending <= expected_words.size();
    end

endmodule

[verif/tb.sv]
// top of the packet framer testbench: clock, reset, stream stimulus and verdict
// depends on rpf_pkg, rpf_frame_checker.sv (rpf_tb_pkg) and radio_packet_framer_crc16
`timescale 1ns / 1ps

module tb;

    import rpf_pkg::*;
    import rpf_tb_pkg::*;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // data_byte[7:0], tx_length[14:8]
    logic        s_tuser  = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // out_byte[7:0], rx_length[14:8], crc_ok[15], error_code[17:16]
    logic [1:0]  m_tuser;         // kind
    logic        m_tlast;

    int errors;
    int pending;
    int items_sent = 0;
    int stall_left = 0;
    bit no_gaps    = 1'b0;

    radio_packet_framer_crc16 dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rpf_frame_checker u_frame_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, 8);
        if (r < 97) return $urandom_range(9, 63);
        return MAX_PAYLOAD;
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = no_gaps ? 0 : pick_gap();
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] data, input logic [6:0] len);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, len, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // receive words mixed in while transmitting give busy errors
    task automatic send_tx_packet(input int len, input int noise_pct);
        send_word(OP_TX, 8'($urandom), 7'(len));
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word(OP_RX, 8'($urandom), 7'($urandom));
            send_word(OP_TX, 8'($urandom), 7'($urandom));
        end
    endtask

    task automatic send_rx_packet(input int len, input bit spoil, input int noise_pct);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = crc16_update(16'h0000, 8'(len));
        send_word(OP_RX, 8'(len), 7'($urandom));
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom);
            crc = crc16_update(crc, b);
            if ($urandom_range(0, 99) < noise_pct)
                send_word(OP_TX, 8'($urandom), 7'($urandom));
            send_word(OP_RX, b, 7'($urandom));
        end
        if (spoil) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_word(OP_RX, crc[7:0], 7'($urandom));
        send_word(OP_RX, crc[15:8], 7'($urandom));
    endtask

    initial begin
        int r;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        send_tx_packet(0, 0);
        send_word(OP_TX, 8'hFF, 7'd1);
        send_word(OP_TX, 8'h00, 7'd65);
        send_word(OP_TX, 8'hFF, 7'h7F);
        send_tx_packet(3, 100);
        send_rx_packet(2, 1'b0, 100);
        send_rx_packet(0, 1'b1, 0);
        send_word(OP_RX, 8'd65, 7'd0);
        send_word(OP_RX, 8'hFF, 7'h7F);

        // random part, with a stretch of no idling in the middle
        while (items_sent < 450) begin
            no_gaps = (items_sent >= 180 && items_sent < 280);
            r = $urandom_range(0, 99);
            if (r < 43) begin
                send_tx_packet(pick_len(), 4);
            end else if (r < 86) begin
                send_rx_packet(pick_len(), $urandom_range(0, 3) == 0, 4);
            end else if (r < 96) begin
                if ($urandom_range(0, 1))
                    send_word(OP_TX, 8'($urandom), 7'($urandom_range(65, 127)));
                else
                    send_word(OP_RX, 8'($urandom_range(65, 255)), 7'($urandom));
            end else begin
                send_word(1'($urandom), 8'($urandom), 7'($urandom));
            end
        end
        no_gaps = 1'b0;
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
